// File: hw/rtl/apbt_pkg.sv
// ----------------------------------------------------------------------------
// apbt_pkg
// Shared constants and types of the affine point and box transform core.
// ----------------------------------------------------------------------------
package apbt_pkg;

  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;

  // Mode bit meanings: bit 0 selects the inverse map, bit 1 selects box input.
  localparam int MODE_INV_BIT = 0;
  localparam int MODE_BOX_BIT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic inverse;
  } apbt_ctrl_t;

endpackage

// File: hw/rtl/apbt_cfg.sv
// ----------------------------------------------------------------------------
// apbt_cfg
// Basis and translation registers, written through the configuration port.
// ----------------------------------------------------------------------------
module apbt_cfg import apbt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 16,
  localparam int CfgDataW  = (3 * COEF_BITS > COORD_BITS) ? 3 * COEF_BITS : COORD_BITS
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                            cfg_index_i,
  input  logic [CfgDataW-1:0]                             cfg_data_i,
  output logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] coef_o,
  output logic [NUM_AXES-1:0][COORD_BITS-1:0]              shift_o
);

  localparam logic [COEF_BITS-1:0] CoefOne = {2'b01, {(COEF_BITS-2){1'b0}}};

  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] rows_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          rows_q[r][c] <= (r == c) ? CoefOne : '0;
        end
        shift_q[r] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      // indexes past the register list drop the transaction
      case (cfg_reg_e'(cfg_index_i))
        REG_ROW_X:   rows_q[0]  <= cfg_data_i[3*COEF_BITS-1:0];
        REG_ROW_Y:   rows_q[1]  <= cfg_data_i[3*COEF_BITS-1:0];
        REG_ROW_Z:   rows_q[2]  <= cfg_data_i[3*COEF_BITS-1:0];
        REG_SHIFT_X: shift_q[0] <= cfg_data_i[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_q[1] <= cfg_data_i[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_q[2] <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign coef_o  = rows_q;
  assign shift_o = shift_q;

endmodule

// File: hw/rtl/apbt_prep.sv
// ----------------------------------------------------------------------------
// apbt_prep
// Operand stage: removes the translation for the inverse map and orients the
// basis (rows forward, columns inverse) for the multiplier array.
// ----------------------------------------------------------------------------
module apbt_prep import apbt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 16,
  localparam int BaseW     = COORD_BITS + 1
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  apbt_ctrl_t                                      ctrl_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]              pt_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-2:0]              ext_i,
  input  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] coef_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]              shift_i,
  output logic                                            valid_o,
  output logic [NUM_AXES-1:0][BaseW-1:0]                   base_o,
  output logic [NUM_AXES-1:0][COORD_BITS-2:0]              ext_o,
  output logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] mat_o,
  output logic [NUM_AXES-1:0][COORD_BITS-1:0]              off_o
);

  logic                                            valid_q;
  logic [NUM_AXES-1:0][BaseW-1:0]                   base_d, base_q;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] mat_d, mat_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              off_d, off_q;
  logic [NUM_AXES-1:0][COORD_BITS-2:0]              ext_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        mat_d[i][j] = ctrl_i.inverse ? coef_i[j][i] : coef_i[i][j];
      end
      if (ctrl_i.inverse) begin
        base_d[i] = {pt_i[i][COORD_BITS-1], pt_i[i]}
                  - {shift_i[i][COORD_BITS-1], shift_i[i]};
        off_d[i]  = '0;
      end else begin
        base_d[i] = {pt_i[i][COORD_BITS-1], pt_i[i]};
        off_d[i]  = shift_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mat_q  <= mat_d;
    off_q  <= off_d;
    ext_q  <= ext_i;
  end

  assign valid_o = valid_q;
  assign base_o  = base_q;
  assign ext_o   = ext_q;
  assign mat_o   = mat_q;
  assign off_o   = off_q;

endmodule

// File: hw/rtl/apbt_mul.sv
// ----------------------------------------------------------------------------
// apbt_mul
// Multiplier array and truncation: full-width products of each coefficient
// with the base coordinate and with the extent, then both candidate terms
// (near and far corner) floored by the coefficient fraction bits.
// ----------------------------------------------------------------------------
module apbt_mul import apbt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 16,
  localparam int BaseW     = COORD_BITS + 1,
  localparam int ProdW     = BaseW + COEF_BITS,
  localparam int FracW     = COEF_BITS - 2,
  localparam int TermW     = ProdW - FracW
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic [NUM_AXES-1:0][BaseW-1:0]                   base_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-2:0]              ext_i,
  input  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] mat_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]              off_i,
  output logic                                            valid_o,
  output logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]     near_o,
  output logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]     far_o,
  output logic [NUM_AXES-1:0][COORD_BITS-1:0]              off_o
);

  logic                                            prod_valid_q, term_valid_q;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][ProdW-1:0]     prod_b_d, prod_b_q;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][ProdW-2:0]     prod_e_d, prod_e_q;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]     near_d, near_q, far_d, far_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              off_p_q, off_t_q;

  // Stage A: products
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        prod_b_d[i][j] = $signed(mat_i[i][j]) * $signed(base_i[j]);
        prod_e_d[i][j] = $signed(mat_i[i][j]) * $signed({1'b0, ext_i[j]});
      end
    end
  end

  // Stage B: floor the near product and the near+far sum
  always_comb begin
    logic [ProdW-1:0] sum_v;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        sum_v        = prod_b_q[i][j] + {prod_e_q[i][j][ProdW-2], prod_e_q[i][j]};
        near_d[i][j] = prod_b_q[i][j][ProdW-1:FracW];
        far_d[i][j]  = sum_v[ProdW-1:FracW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      term_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      term_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_b_q <= prod_b_d;
    prod_e_q <= prod_e_d;
    off_p_q  <= off_i;
    near_q   <= near_d;
    far_q    <= far_d;
    off_t_q  <= off_p_q;
  end

  assign valid_o = term_valid_q;
  assign near_o  = near_q;
  assign far_o   = far_q;
  assign off_o   = off_t_q;

endmodule

// File: hw/rtl/apbt_corner.sv
// ----------------------------------------------------------------------------
// apbt_corner
// Corner stage: sums the three terms picked by each corner's code plus the
// offset and saturates every transformed corner to the coordinate range.
// ----------------------------------------------------------------------------
module apbt_corner import apbt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 16,
  localparam int TermW     = (COORD_BITS + 1 + COEF_BITS) - (COEF_BITS - 2),
  localparam int SumW      = COORD_BITS + 5
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]      near_i,
  input  logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]      far_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]               off_i,
  output logic                                             valid_o,
  output logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] corner_o
);

  localparam logic [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CoordMin = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                                                 valid_q;
  logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] corner_d, corner_q;

  always_comb begin
    logic [SumW-1:0]  acc_v;
    logic [TermW-1:0] term_v;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        acc_v = {{(SumW-COORD_BITS){off_i[i][COORD_BITS-1]}}, off_i[i]};
        for (int j = 0; j < NUM_AXES; j++) begin
          term_v = (((k >> j) & 1) != 0) ? far_i[i][j] : near_i[i][j];
          acc_v  = acc_v + {{(SumW-TermW){term_v[TermW-1]}}, term_v};
        end
        if (acc_v[SumW-1:COORD_BITS-1] == {(SumW-COORD_BITS+1){acc_v[SumW-1]}}) begin
          corner_d[k][i] = acc_v[COORD_BITS-1:0];
        end else begin
          corner_d[k][i] = acc_v[SumW-1] ? CoordMin : CoordMax;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    corner_q <= corner_d;
  end

  assign valid_o  = valid_q;
  assign corner_o = corner_q;

endmodule

// File: hw/rtl/apbt_bound.sv
// ----------------------------------------------------------------------------
// apbt_bound
// Bounding stage: registered min/max tree over the eight corners, then the
// min corner and the saturated extent as the result registers.
// ----------------------------------------------------------------------------
module apbt_bound import apbt_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  input  logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] corner_i,
  output logic                                                 done_o,
  output logic [NUM_AXES-1:0][COORD_BITS-1:0]                  lo_o,
  output logic [NUM_AXES-1:0][COORD_BITS-2:0]                  span_o
);

  localparam int Half = NUM_CORNERS / 2;
  localparam int Quarter = NUM_CORNERS / 4;

  logic                                             pair_valid_q, fin_valid_q, done_q;
  logic [Quarter-1:0][NUM_AXES-1:0][COORD_BITS-1:0] pmin_d, pmin_q, pmax_d, pmax_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              lo_d, lo_q, hi_d, hi_q, out_q;
  logic [NUM_AXES-1:0][COORD_BITS-2:0]              span_d, span_q;

  // Tree levels one and two: eight corners down to two per axis
  always_comb begin
    logic [Half-1:0][COORD_BITS-1:0] mn_v, mx_v;
    logic [COORD_BITS-1:0]           a_v, b_v;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int p = 0; p < Half; p++) begin
        a_v = corner_i[2*p][i];
        b_v = corner_i[2*p+1][i];
        if ($signed(a_v) < $signed(b_v)) begin
          mn_v[p] = a_v;
          mx_v[p] = b_v;
        end else begin
          mn_v[p] = b_v;
          mx_v[p] = a_v;
        end
      end
      for (int q = 0; q < Quarter; q++) begin
        pmin_d[q][i] = ($signed(mn_v[2*q]) < $signed(mn_v[2*q+1])) ? mn_v[2*q]
                                                                  : mn_v[2*q+1];
        pmax_d[q][i] = ($signed(mx_v[2*q]) > $signed(mx_v[2*q+1])) ? mx_v[2*q]
                                                                  : mx_v[2*q+1];
      end
    end
  end

  // Tree level three
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_d[i] = ($signed(pmin_q[0][i]) < $signed(pmin_q[1][i])) ? pmin_q[0][i]
                                                               : pmin_q[1][i];
      hi_d[i] = ($signed(pmax_q[0][i]) > $signed(pmax_q[1][i])) ? pmax_q[0][i]
                                                               : pmax_q[1][i];
    end
  end

  // Extent: hi - lo is never negative; clamp to the span field
  always_comb begin
    logic [COORD_BITS:0] diff_v;
    for (int i = 0; i < NUM_AXES; i++) begin
      diff_v = {hi_q[i][COORD_BITS-1], hi_q[i]} - {lo_q[i][COORD_BITS-1], lo_q[i]};
      if (diff_v[COORD_BITS:COORD_BITS-1] != 2'b00) begin
        span_d[i] = '1;
      end else begin
        span_d[i] = diff_v[COORD_BITS-2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      fin_valid_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      pair_valid_q <= valid_i;
      fin_valid_q  <= pair_valid_q;
      done_q       <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pmin_q <= pmin_d;
    pmax_q <= pmax_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    out_q  <= lo_q;
    span_q <= span_d;
  end

  assign done_o = done_q;
  assign lo_o   = out_q;
  assign span_o = span_q;

endmodule

// File: hw/rtl/affine_point_and_box_transform_core.sv
// ----------------------------------------------------------------------------
// affine_point_and_box_transform_core
// Applies a 3x3 Q2.14 basis and a Q16.16 translation to points and to
// axis-aligned boxes, forward or inverse (transposed basis).
// ----------------------------------------------------------------------------
// An item is taken at every clock edge where start is high and busy is low;
// busy is high only in the first cycle after reset, so one item can enter in
// every cycle. Each result appears on the out_*/span_* ports for a single
// cycle with done_o high, in the order the items were taken. The receiver
// cannot stall the core and the pipeline never holds, so a result must be
// captured in its done cycle. Each item passes through the chain of
// registered stages: input register, operand prep, 18-multiplier array,
// truncation, corner sum and saturation, two min/max tree stages and the
// extent register. Box items evaluate all eight corners in parallel, so
// points and boxes take the same time. Write the configuration registers
// only while no item is in flight.
// ----------------------------------------------------------------------------
module affine_point_and_box_transform_core import apbt_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 16,
  localparam int CfgDataW  = (3 * COEF_BITS > COORD_BITS) ? 3 * COEF_BITS : COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [MODE_W-1:0]            mode_i,
  input  logic signed [COORD_BITS-1:0] in_x_i,
  input  logic signed [COORD_BITS-1:0] in_y_i,
  input  logic signed [COORD_BITS-1:0] in_z_i,
  input  logic [COORD_BITS-2:0]        ext_x_i,
  input  logic [COORD_BITS-2:0]        ext_y_i,
  input  logic [COORD_BITS-2:0]        ext_z_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic signed [COORD_BITS-1:0] out_z_o,
  output logic [COORD_BITS-2:0]        span_x_o,
  output logic [COORD_BITS-2:0]        span_y_o,
  output logic [COORD_BITS-2:0]        span_z_o
);

  localparam int BaseW = COORD_BITS + 1;
  localparam int TermW = COORD_BITS + 3;

  logic                                            live_q;
  logic                                            accept;
  apbt_ctrl_t                                      ctrl_d, ctrl_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              pt_q;
  logic [NUM_AXES-1:0][COORD_BITS-2:0]              ext_d, ext_q;

  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] coef;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              shift;

  logic                                            prep_valid;
  logic [NUM_AXES-1:0][BaseW-1:0]                   prep_base;
  logic [NUM_AXES-1:0][COORD_BITS-2:0]              prep_ext;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_BITS-1:0] prep_mat;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              prep_off;

  logic                                            mul_valid;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][TermW-1:0]     mul_near, mul_far;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]              mul_off;

  logic                                                 crn_valid;
  logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] crn_val;

  logic [NUM_AXES-1:0][COORD_BITS-1:0]              res_lo;
  logic [NUM_AXES-1:0][COORD_BITS-2:0]              res_span;

  assign busy   = !live_q;
  assign accept = start && !busy;

  always_comb begin
    ctrl_d.valid   = accept;
    ctrl_d.inverse = mode_i[MODE_INV_BIT];
    // a point is a box of zero extent: all corners coincide, span comes out zero
    ext_d[0] = mode_i[MODE_BOX_BIT] ? ext_x_i : '0;
    ext_d[1] = mode_i[MODE_BOX_BIT] ? ext_y_i : '0;
    ext_d[2] = mode_i[MODE_BOX_BIT] ? ext_z_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      ctrl_q <= '0;
    end else begin
      live_q <= 1'b1;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q[0] <= in_x_i;
    pt_q[1] <= in_y_i;
    pt_q[2] <= in_z_i;
    ext_q   <= ext_d;
  end

  apbt_cfg #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .shift_o     (shift)
  );

  apbt_prep #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_q),
    .pt_i    (pt_q),
    .ext_i   (ext_q),
    .coef_i  (coef),
    .shift_i (shift),
    .valid_o (prep_valid),
    .base_o  (prep_base),
    .ext_o   (prep_ext),
    .mat_o   (prep_mat),
    .off_o   (prep_off)
  );

  apbt_mul #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .base_i  (prep_base),
    .ext_i   (prep_ext),
    .mat_i   (prep_mat),
    .off_i   (prep_off),
    .valid_o (mul_valid),
    .near_o  (mul_near),
    .far_o   (mul_far),
    .off_o   (mul_off)
  );

  apbt_corner #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_corner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .near_i   (mul_near),
    .far_i    (mul_far),
    .off_i    (mul_off),
    .valid_o  (crn_valid),
    .corner_o (crn_val)
  );

  apbt_bound #(
    .COORD_BITS (COORD_BITS)
  ) u_bound (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (crn_valid),
    .corner_i (crn_val),
    .done_o   (done_o),
    .lo_o     (res_lo),
    .span_o   (res_span)
  );

  assign out_x_o  = res_lo[0];
  assign out_y_o  = res_lo[1];
  assign out_z_o  = res_lo[2];
  assign span_x_o = res_span[0];
  assign span_y_o = res_span[1];
  assign span_z_o = res_span[2];

endmodule
